[rtl/gss_pkg.sv]
// ---------------------------------------------------------------------------
// Gradient sharpness statistics package
// Shared sizes, register indexes and reset values of the focus-measure block.
// ---------------------------------------------------------------------------
package gss_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W   = 13;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int PIXEL_W = 8;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = DIM_W;

	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;
	localparam logic [DIM_W-1:0] DIM_MIN            = 13'd3;
	localparam logic [DIM_W-1:0] WIDTH_MAX          = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX         = DIM_W'(MAX_HEIGHT);

	localparam int ABS_SUM_W = 32;
	localparam int LAP_SUM_W = 44;
	localparam int SOB_SUM_W = 45;
	localparam int COUNT_W   = 24;

	localparam int GRAD_W   = 12;
	localparam int SQUARE_W = 21;

	localparam longint ABS_MAX    = 255;
	localparam longint SQUARE_MAX = 1040400;

endpackage

[rtl/gss_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ---------------------------------------------------------------------------
module gss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/gradient_sharpness_statistics.sv]
// A frame's sums pass stages 1, 2 and 3, then the output register.
// One pixel per unstalled cycle; the line memory is read and written once per cycle.
// Input stalls only while a result waits and the next frame's result is complete.
// Reset: control and sums clear, frame size returns to 1920 x 1080.
// The line memory is not cleared; its contents are defined once written.
// ---------------------------------------------------------------------------
// Gradient sharpness statistics
// Streams raster pixels through a two-line memory and a 3x3 window and sums
// absolute differences, squared Laplacian and Sobel energy per frame.
// ---------------------------------------------------------------------------
module gradient_sharpness_statistics (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gss_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gss_pkg::PIXEL_W-1:0]       pixel,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_horizontal,
	output logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_vertical,
	output logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_diag_falling,
	output logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_diag_rising,
	output logic [gss_pkg::LAP_SUM_W-1:0]     sum_laplacian_squared,
	output logic [gss_pkg::SOB_SUM_W-1:0]     sum_sobel_energy,
	output logic [gss_pkg::COUNT_W-1:0]       interior_count
);

	localparam int PW = gss_pkg::PIXEL_W;
	localparam int CW = gss_pkg::COL_W;
	localparam int RW = gss_pkg::ROW_W;
	localparam int DW = gss_pkg::DIM_W;
	localparam int GW = gss_pkg::GRAD_W;
	localparam int SW = gss_pkg::SQUARE_W;

	logic [DW-1:0] frame_width_q, frame_height_q;
	logic [DW-1:0] width_eff, height_eff;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic          line_end, frame_end;
	logic          adv, accept;

	logic          s1_valid, s1_interior, s1_emit, s1_clear, s1_fwd;
	logic [PW-1:0] s1_pixel;
	logic [CW-1:0] s1_col;
	logic [2*PW-1:0] s1_fwd_data;
	logic [2*PW-1:0] ram_rdata;
	logic [PW-1:0] nt, nm, nb;
	logic          s1_fire;

	logic [PW-1:0] win_q [6];

	logic          s2_valid, s2_interior, s2_emit, s2_clear;
	logic [PW-1:0] s2_ad [4];
	logic signed [GW-1:0] s2_lap, s2_gx, s2_gy;

	logic          s3_valid, s3_interior, s3_emit, s3_clear;
	logic [PW-1:0] s3_ad [4];
	logic [SW-1:0] s3_lap2, s3_gx2, s3_gy2;

	logic [gss_pkg::ABS_SUM_W-1:0] abs_acc_q [4];
	logic [gss_pkg::LAP_SUM_W-1:0] lap_acc_q;
	logic [gss_pkg::SOB_SUM_W-1:0] sob_acc_q;
	logic [gss_pkg::COUNT_W-1:0]   cnt_acc_q;
	logic [gss_pkg::ABS_SUM_W-1:0] abs_next [4];
	logic [gss_pkg::LAP_SUM_W-1:0] lap_next;
	logic [gss_pkg::SOB_SUM_W-1:0] sob_next;
	logic [gss_pkg::COUNT_W-1:0]   cnt_next;

	logic out_valid_q;

	function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gss_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= gss_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gss_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				gss_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		width_eff = frame_width_q;
		if (frame_width_q < gss_pkg::DIM_MIN) width_eff = gss_pkg::DIM_MIN;
		else if (frame_width_q > gss_pkg::WIDTH_MAX) width_eff = gss_pkg::WIDTH_MAX;
		height_eff = frame_height_q;
		if (frame_height_q < gss_pkg::DIM_MIN) height_eff = gss_pkg::DIM_MIN;
		else if (frame_height_q > gss_pkg::HEIGHT_MAX) height_eff = gss_pkg::HEIGHT_MAX;
	end

	// Position of the incoming pixel.
	always_comb begin
		col_cur = frame_start ? '0 : col_q;
		row_cur = frame_start ? '0 : row_q;
		if ({1'b0, col_cur} >= width_eff) col_cur = CW'(width_eff - DW'(1));
		if ({1'b0, row_cur} >= height_eff) row_cur = RW'(height_eff - DW'(1));
		line_end  = ({1'b0, col_cur} + DW'(1)) >= width_eff;
		frame_end = line_end && (({1'b0, row_cur} + DW'(1)) >= height_eff);
	end

	assign adv      = !(s3_valid && s3_emit && out_valid_q && !out_ready);
	assign in_ready = adv;
	assign accept   = in_valid && adv;
	assign s1_fire  = adv && s1_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (line_end) begin
				col_q <= '0;
				row_q <= row_cur + RW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// Line memory: upper byte two lines above, lower byte one line above.
	gss_ram #(
		.WIDTH(2 * PW),
		.DEPTH(gss_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(s1_col),
		.wdata({nm, nb}),
		.re   (accept),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_pixel    <= pixel;
			s1_col      <= col_cur;
			s1_interior <= (col_cur >= CW'(2)) && (row_cur >= RW'(2));
			s1_emit     <= frame_end;
			s1_clear    <= frame_start;
			s1_fwd      <= s1_fire && (s1_col == col_cur);
			s1_fwd_data <= {nm, nb};
		end
	end

	assign nt = s1_fwd ? s1_fwd_data[2*PW-1:PW] : ram_rdata[2*PW-1:PW];
	assign nm = s1_fwd ? s1_fwd_data[PW-1:0]    : ram_rdata[PW-1:0];
	assign nb = s1_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (s1_fire) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= nt;
			win_q[1] <= nm;
			win_q[2] <= nb;
		end
	end

	// Stage 2: differences, gradients and Laplacian.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			s2_interior <= s1_interior;
			s2_emit     <= s1_emit;
			s2_clear    <= s1_clear;
			s2_ad[0]    <= abs_diff(nm, win_q[4]);
			s2_ad[1]    <= abs_diff(win_q[2], win_q[0]);
			s2_ad[2]    <= abs_diff(nb, win_q[3]);
			s2_ad[3]    <= abs_diff(win_q[5], nt);
			s2_gx  <= (GW'(nt) + (GW'(nm) << 1) + GW'(nb))
				- (GW'(win_q[3]) + (GW'(win_q[4]) << 1) + GW'(win_q[5]));
			s2_gy  <= (GW'(win_q[5]) + (GW'(win_q[2]) << 1) + GW'(nb))
				- (GW'(win_q[3]) + (GW'(win_q[0]) << 1) + GW'(nt));
			s2_lap <= (GW'(win_q[1]) << 2) - GW'(win_q[4]) - GW'(nm)
				- GW'(win_q[0]) - GW'(win_q[2]);
		end
	end

	// Stage 3: squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (adv) begin
			s3_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_valid) begin
			s3_interior <= s2_interior;
			s3_emit     <= s2_emit;
			s3_clear    <= s2_clear;
			for (int i = 0; i < 4; i++) s3_ad[i] <= s2_ad[i];
			s3_lap2 <= SW'(s2_lap * s2_lap);
			s3_gx2  <= SW'(s2_gx * s2_gx);
			s3_gy2  <= SW'(s2_gy * s2_gy);
		end
	end

	// Accumulation.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			abs_next[i] = (s3_clear ? '0 : abs_acc_q[i])
				+ (s3_interior ? gss_pkg::ABS_SUM_W'(s3_ad[i]) : '0);
		end
		lap_next = (s3_clear ? '0 : lap_acc_q)
			+ (s3_interior ? gss_pkg::LAP_SUM_W'(s3_lap2) : '0);
		sob_next = (s3_clear ? '0 : sob_acc_q)
			+ (s3_interior ? (gss_pkg::SOB_SUM_W'(s3_gx2) + gss_pkg::SOB_SUM_W'(s3_gy2)) : '0);
		cnt_next = (s3_clear ? '0 : cnt_acc_q)
			+ (s3_interior ? gss_pkg::COUNT_W'(1) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) abs_acc_q[i] <= '0;
			lap_acc_q <= '0;
			sob_acc_q <= '0;
			cnt_acc_q <= '0;
		end else if (adv && s3_valid) begin
			if (s3_emit) begin
				for (int i = 0; i < 4; i++) abs_acc_q[i] <= '0;
				lap_acc_q <= '0;
				sob_acc_q <= '0;
				cnt_acc_q <= '0;
			end else begin
				for (int i = 0; i < 4; i++) abs_acc_q[i] <= abs_next[i];
				lap_acc_q <= lap_next;
				sob_acc_q <= sob_next;
				cnt_acc_q <= cnt_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s3_valid && s3_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s3_valid && s3_emit) begin
			sum_abs_horizontal    <= abs_next[0];
			sum_abs_vertical      <= abs_next[1];
			sum_abs_diag_falling  <= abs_next[2];
			sum_abs_diag_rising   <= abs_next[3];
			sum_laplacian_squared <= lap_next;
			sum_sobel_energy      <= sob_next;
			interior_count        <= cnt_next;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/gss_checker.sv]
// ---------------------------------------------------------------------------
// Gradient sharpness statistics checker
// Port-level properties of the handshakes and bounds on each reported result.
// ---------------------------------------------------------------------------
module gss_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [gss_pkg::PIXEL_W-1:0]       pixel,
	input logic                              frame_start,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_horizontal,
	input logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_vertical,
	input logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_diag_falling,
	input logic [gss_pkg::ABS_SUM_W-1:0]     sum_abs_diag_rising,
	input logic [gss_pkg::LAP_SUM_W-1:0]     sum_laplacian_squared,
	input logic [gss_pkg::SOB_SUM_W-1:0]     sum_sobel_energy,
	input logic [gss_pkg::COUNT_W-1:0]       interior_count
);

	logic [63:0] count_64;

	assign count_64 = 64'(interior_count);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pixel) && $stable(frame_start))
		else $error("Input transaction changed while stalled.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_abs_horizontal)
			&& $stable(sum_sobel_energy) && $stable(interior_count))
		else $error("Result transaction changed while stalled.");

	a_abs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (64'(sum_abs_horizontal) <= count_64 * gss_pkg::ABS_MAX)
			&& (64'(sum_abs_vertical) <= count_64 * gss_pkg::ABS_MAX)
			&& (64'(sum_abs_diag_falling) <= count_64 * gss_pkg::ABS_MAX)
			&& (64'(sum_abs_diag_rising) <= count_64 * gss_pkg::ABS_MAX))
		else $error("Absolute difference sum exceeds its bound for the interior count.");

	a_energy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (64'(sum_laplacian_squared) <= count_64 * gss_pkg::SQUARE_MAX)
			&& (64'(sum_sobel_energy) <= count_64 * (2 * gss_pkg::SQUARE_MAX)))
		else $error("Energy sum exceeds its bound for the interior count.");

endmodule

bind gradient_sharpness_statistics gss_checker u_gss_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient sharpness statistics testbench
// Streams raster frames of many sizes through the focus-measure block with
// random gaps on the pixel side and random stalls on the result side. A few
// hand-built 3x3 frames carry their expected sums directly. Every other frame
// is checked field by field against a behavioural predictor of the window sums.
// ---------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [gss_pkg::ABS_SUM_W-1:0] horiz;
		logic [gss_pkg::ABS_SUM_W-1:0] vert;
		logic [gss_pkg::ABS_SUM_W-1:0] diag_fall;
		logic [gss_pkg::ABS_SUM_W-1:0] diag_rise;
		logic [gss_pkg::LAP_SUM_W-1:0] lap;
		logic [gss_pkg::SOB_SUM_W-1:0] sobel;
		logic [gss_pkg::COUNT_W-1:0]   count;
	} focus_stats_t;

	typedef struct packed {
		logic [gss_pkg::PIXEL_W-1:0] pix;
		logic                        start;
		logic                        typed;
		focus_stats_t                want;
	} stim_row_t;

	localparam focus_stats_t NO_STATS = '0;
	localparam focus_stats_t CENTRE_PEAK =
		'{32'd0, 32'd0, 32'd0, 32'd0, 44'd1040400, 45'd0, 24'd1};
	localparam focus_stats_t RIGHT_EDGE =
		'{32'd255, 32'd0, 32'd255, 32'd255, 44'd65025, 45'd1040400, 24'd1};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [gss_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [gss_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [gss_pkg::PIXEL_W-1:0]     pixel;
	logic                            frame_start;
	logic                            out_valid;
	logic                            out_ready;
	logic [gss_pkg::ABS_SUM_W-1:0]   sum_abs_horizontal;
	logic [gss_pkg::ABS_SUM_W-1:0]   sum_abs_vertical;
	logic [gss_pkg::ABS_SUM_W-1:0]   sum_abs_diag_falling;
	logic [gss_pkg::ABS_SUM_W-1:0]   sum_abs_diag_rising;
	logic [gss_pkg::LAP_SUM_W-1:0]   sum_laplacian_squared;
	logic [gss_pkg::SOB_SUM_W-1:0]   sum_sobel_energy;
	logic [gss_pkg::COUNT_W-1:0]     interior_count;

	gradient_sharpness_statistics dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bit [gss_pkg::DIM_W-1:0]   width_setting  = gss_pkg::FRAME_WIDTH_RESET;
	bit [gss_pkg::DIM_W-1:0]   height_setting = gss_pkg::FRAME_HEIGHT_RESET;
	bit [gss_pkg::PIXEL_W-1:0] mem_row_above [gss_pkg::MAX_WIDTH];
	bit [gss_pkg::PIXEL_W-1:0] mem_row_two_above [gss_pkg::MAX_WIDTH];
	int                        window_px [6];
	int unsigned               col_now;
	int unsigned               row_now;
	bit [63:0]                 abs_acc [4];
	bit [63:0]                 lap_acc;
	bit [63:0]                 sobel_acc;
	bit [31:0]                 interior_acc;

	focus_stats_t expected_stats [$];
	int           mismatch_count;
	int           random_items;
	bit           tx_quiet;
	bit           rx_quiet;

	stim_row_t directed_rows [20] = '{
		'{8'd0,   1'b1, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b1, CENTRE_PEAK},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b1, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b1, RIGHT_EDGE}
	};

	function automatic int unsigned clamp_size(bit [gss_pkg::DIM_W-1:0] v,
			bit [gss_pkg::DIM_W-1:0] hi);
		if (v < gss_pkg::DIM_MIN) return gss_pkg::DIM_MIN;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int abs_of(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void restart_frame_sums();
		col_now = 0;
		row_now = 0;
		foreach (abs_acc[i]) abs_acc[i] = '0;
		lap_acc = '0;
		sobel_acc = '0;
		interior_acc = '0;
	endfunction

	function automatic void accumulate_pixel(input bit [gss_pkg::PIXEL_W-1:0] pix,
			input bit start, output bit done, output focus_stats_t stats);
		int unsigned w, h, c, r;
		int tl, up, tr, lf, ct, rt, bl, dn, br, gx, gy, lap;
		w = clamp_size(width_setting, gss_pkg::WIDTH_MAX);
		h = clamp_size(height_setting, gss_pkg::HEIGHT_MAX);
		done = 1'b0;
		stats = '0;
		if (start) restart_frame_sums();
		if (col_now >= w) col_now = w - 1;
		if (row_now >= h) row_now = h - 1;
		c = col_now;
		r = row_now;
		tr = mem_row_two_above[c];
		rt = mem_row_above[c];
		br = pix;
		if (c >= 2 && r >= 2) begin
			up = window_px[0];
			ct = window_px[1];
			dn = window_px[2];
			tl = window_px[3];
			lf = window_px[4];
			bl = window_px[5];
			gx = (tr + 2 * rt + br) - (tl + 2 * lf + bl);
			gy = (bl + 2 * dn + br) - (tl + 2 * up + tr);
			lap = 4 * ct - lf - rt - up - dn;
			abs_acc[0] += 64'(abs_of(rt - lf));
			abs_acc[1] += 64'(abs_of(dn - up));
			abs_acc[2] += 64'(abs_of(br - tl));
			abs_acc[3] += 64'(abs_of(bl - tr));
			lap_acc += 64'(lap * lap);
			sobel_acc += 64'(gx * gx + gy * gy);
			interior_acc++;
		end
		window_px[3] = window_px[0];
		window_px[4] = window_px[1];
		window_px[5] = window_px[2];
		window_px[0] = tr;
		window_px[1] = rt;
		window_px[2] = br;
		mem_row_two_above[c] = 8'(rt);
		mem_row_above[c] = 8'(br);
		if (c + 1 >= w) begin
			if (r + 1 >= h) begin
				stats.horiz = abs_acc[0][gss_pkg::ABS_SUM_W-1:0];
				stats.vert = abs_acc[1][gss_pkg::ABS_SUM_W-1:0];
				stats.diag_fall = abs_acc[2][gss_pkg::ABS_SUM_W-1:0];
				stats.diag_rise = abs_acc[3][gss_pkg::ABS_SUM_W-1:0];
				stats.lap = lap_acc[gss_pkg::LAP_SUM_W-1:0];
				stats.sobel = sobel_acc[gss_pkg::SOB_SUM_W-1:0];
				stats.count = interior_acc[gss_pkg::COUNT_W-1:0];
				done = 1'b1;
				restart_frame_sums();
			end else begin
				col_now = 0;
				row_now = r + 1;
			end
		end else begin
			col_now = c + 1;
		end
	endfunction

	function automatic int pick_gap();
		int roll;
		if (tx_quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	function automatic bit [gss_pkg::PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return gss_pkg::PIXEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic bit [gss_pkg::DIM_W-1:0] pick_size(int unsigned top);
		if ($urandom_range(0, 9) == 0) return gss_pkg::DIM_W'($urandom_range(0, 2));
		return gss_pkg::DIM_W'($urandom_range(3, top));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic write_register(input logic [gss_pkg::CFG_INDEX_W-1:0] idx,
			input bit [gss_pkg::DIM_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == gss_pkg::CFG_FRAME_WIDTH) width_setting = val;
		else height_setting = val;
	endtask

	task automatic program_frame_size(input bit [gss_pkg::DIM_W-1:0] w,
			input bit [gss_pkg::DIM_W-1:0] h);
		write_register(gss_pkg::CFG_FRAME_WIDTH, w);
		write_register(gss_pkg::CFG_FRAME_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// With no gap due, the next transaction follows without valid being dropped.
	task automatic send_pixel(input bit [gss_pkg::PIXEL_W-1:0] pix, input bit start,
			input bit typed, input focus_stats_t typed_stats, output bit done);
		int gap;
		focus_stats_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= pix;
		frame_start <= start;
		do @(posedge clk); while (!in_ready);
		accumulate_pixel(pix, start, done, predicted);
		if (typed) expected_stats.push_back(typed_stats);
		else if (done) expected_stats.push_back(predicted);
	endtask

	task automatic send_frame(input bit start, input int resize_at, output int sent);
		bit done;
		sent = 0;
		do begin
			if (sent == resize_at) begin
				drain_and_settle();
				if ($urandom_range(0, 1) == 1) begin
					write_register(gss_pkg::CFG_FRAME_WIDTH, gss_pkg::DIM_W'($urandom_range(0,
						clamp_size(width_setting, gss_pkg::WIDTH_MAX))));
				end else begin
					write_register(gss_pkg::CFG_FRAME_HEIGHT,
						gss_pkg::DIM_W'($urandom_range(0, 10)));
				end
				cfg_we <= 1'b0;
			end
			send_pixel(pick_pixel(), start && sent == 0, 1'b0, NO_STATS, done);
			sent++;
		end while (!done);
	endtask

	initial begin
		focus_stats_t got;
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{sum_abs_horizontal, sum_abs_vertical, sum_abs_diag_falling,
					sum_abs_diag_rising, sum_laplacian_squared, sum_sobel_energy,
					interior_count};
				if (expected_stats.size() == 0) begin
					report_mismatch("result arrived with no frame awaiting one");
				end else begin
					focus_stats_t want;
					want = expected_stats.pop_front();
					check_field("sum_abs_horizontal", got.horiz, want.horiz);
					check_field("sum_abs_vertical", got.vert, want.vert);
					check_field("sum_abs_diag_falling", got.diag_fall, want.diag_fall);
					check_field("sum_abs_diag_rising", got.diag_rise, want.diag_rise);
					check_field("sum_laplacian_squared", got.lap, want.lap);
					check_field("sum_sobel_energy", got.sobel, want.sobel);
					check_field("interior_count", got.count, want.count);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		bit [gss_pkg::DIM_W-1:0] big_sizes [3][2];
		bit done;
		bit cut_short;
		int sent;
		int unsigned span;
		int resize_at;
		int k;
		big_sizes = '{'{13'd4096, 13'd3}, '{13'd8191, 13'd1}, '{13'd2, 13'd8191}};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= gss_pkg::CFG_FRAME_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pixel <= '0;
		frame_start <= 1'b0;
		mismatch_count = 0;
		random_items = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		restart_frame_sums();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_frame_size(13'd3, 13'd3);
		foreach (directed_rows[i]) begin
			send_pixel(directed_rows[i].pix, directed_rows[i].start, directed_rows[i].typed,
				directed_rows[i].want, done);
		end

		tx_quiet = 1'b1;
		foreach (big_sizes[i]) begin
			drain_and_settle();
			program_frame_size(big_sizes[i][0], big_sizes[i][1]);
			for (int j = 0; j < 48; j++) begin
				send_pixel(pick_pixel(), j == 0, 1'b0, NO_STATS, done);
			end
			random_items += 48;
		end
		drain_and_settle();
		program_frame_size(13'd3, 13'd3);
		send_frame(1'b1, -1, sent);
		random_items += sent;

		while (random_items < 1950) begin
			drain_and_settle();
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			program_frame_size(pick_size(12), pick_size(8));
			repeat ($urandom_range(1, 4)) begin
				span = clamp_size(width_setting, gss_pkg::WIDTH_MAX)
					* clamp_size(height_setting, gss_pkg::HEIGHT_MAX);
				cut_short = ($urandom_range(0, 7) == 0);
				if (cut_short) begin
					k = $urandom_range(1, span - 1);
					for (int i = 0; i < k; i++) begin
						send_pixel(pick_pixel(), i == 0 && $urandom_range(0, 1) == 1, 1'b0,
							NO_STATS, done);
					end
					random_items += k;
				end
				resize_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span - 1) : -1;
				send_frame(cut_short || $urandom_range(0, 1) == 1, resize_at, sent);
				random_items += sent;
			end
		end

		in_valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[gradient_sharpness_statistics] OK");
		end else begin
			$display("[gradient_sharpness_statistics] ERROR");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("[gradient_sharpness_statistics] ERROR");
		$finish;
	end

endmodule

[gradient_sharpness_statistics.f]
rtl/gss_pkg.sv
rtl/gss_ram.sv
rtl/gradient_sharpness_statistics.sv
rtl/gss_checker.sv
dv/tb_top.sv
